// ===== hw/rtl/osa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_pkg
// Shared types and constants for the optimal string alignment distance block.
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int OSA_MAX_LEN_DEF = 64;

  localparam logic [1:0] CMD_REF    = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] character;
  } osa_in_t;

  typedef struct packed {
    logic [6:0] distance;
    logic       overflow;
  } osa_out_t;

  // Token handed from one cell to the next during a row sweep.
  typedef struct packed {
    logic       valid;
    logic       has_left;
    logic [7:0] ref_char;
  } osa_tok_t;

  // Values broadcast to every cell for the duration of a sweep.
  typedef struct packed {
    logic [7:0] q;
    logic [7:0] q_prev;
    logic       i_pos;
    logic       clr;
  } osa_bc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/osa_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_cell
// One reference position of the row: holds its reference byte and two
// row entries, and computes its new entry when the sweep token passes.
// ----------------------------------------------------------------------------
module osa_cell
  import osa_pkg::*;
#(
  parameter int IDX = 0,
  parameter int VW  = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire osa_bc_t       bc,
  input  wire logic          wr_en,
  input  wire logic [7:0]    wr_char,
  input  wire osa_tok_t      tok_in,
  input  wire logic [VW-1:0] left_in,
  input  wire logic [VW-1:0] diag_in,
  input  wire logic [VW-1:0] two_diag_in,
  input  wire logic [VW-1:0] two_far_in,
  output osa_tok_t           tok_out,
  output logic [VW-1:0]      left_out,
  output logic [VW-1:0]      diag_out,
  output logic [VW-1:0]      two_diag_out,
  output logic [VW-1:0]      two_far_out,
  output logic [VW-1:0]      prev_out
);

  logic [7:0]    ref_r;
  logic          loaded_r;
  logic [VW-1:0] prev_r, prev_nxt;
  logic [VW-1:0] two_r;
  logic          tok_valid_r;
  logic [7:0]    tok_char_r;
  logic [VW-1:0] left_r, diag_r, two_diag_r, two_far_r;

  logic [VW-1:0] a_v, b_v, c_v, m_v, t_v;
  logic          mismatch, trans;

  always_comb begin
    mismatch = (bc.q != ref_r);
    a_v      = left_in + VW'(1);
    b_v      = prev_r + VW'(1);
    c_v      = diag_in + VW'(mismatch);
    t_v      = two_far_in + VW'(1);
    m_v      = (a_v < b_v) ? a_v : b_v;
    m_v      = (c_v < m_v) ? c_v : m_v;
    trans    = bc.i_pos && tok_in.has_left && mismatch &&
               (bc.q == tok_in.ref_char) && (ref_r == bc.q_prev);
    prev_nxt = (trans && (t_v < m_v)) ? t_v : m_v;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ref_r <= wr_char;
    end
  end

  // The token stops at the first cell that holds no reference byte.
  always_ff @(posedge clk) begin
    if (!rst_n || bc.clr) begin
      loaded_r <= 1'b0;
    end else if (wr_en) begin
      loaded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || bc.clr) begin
      prev_r <= VW'(IDX + 1);
      two_r  <= VW'(IDX + 1);
    end else if (tok_in.valid && loaded_r) begin
      prev_r <= prev_nxt;
      two_r  <= prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid && loaded_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_char_r <= ref_r;
    left_r     <= prev_nxt;
    diag_r     <= prev_r;
    two_diag_r <= two_r;
    two_far_r  <= two_diag_in;
  end

  assign tok_out      = '{valid: tok_valid_r, has_left: 1'b1, ref_char: tok_char_r};
  assign left_out     = left_r;
  assign diag_out     = diag_r;
  assign two_diag_out = two_diag_r;
  assign two_far_out  = two_far_r;
  assign prev_out     = prev_r;

endmodule

`default_nettype wire

// ===== hw/rtl/osa_edit_distance.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_edit_distance
// Optimal string alignment distance over a row of cells, one cell for each
// reference byte. Each query byte sends a token down the row.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                          Payload
//  in       input      in_valid, in_stall, in_data    osa_in_t
//  out      output     out_valid, out_stall, out_data osa_out_t
//
// A query transaction stalls the input while its token travels once through
// the loaded cells, timed by a counter set to the reference length.
// Reset is synchronous and returns both strings to empty.
// A finish transaction stalls while the previous result is held and stalled.
// ----------------------------------------------------------------------------
module osa_edit_distance
  import osa_pkg::*;
#(
  parameter int MAX_LEN = OSA_MAX_LEN_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire osa_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output osa_out_t     out_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int VW = $clog2(MAX_LEN + 2);

  logic [CW-1:0] ref_count_r, query_count_r, cnt_r;
  logic          ovf_r, busy_r, ipos_r;
  logic [7:0]    qcur_r, qprev_r;
  logic          out_valid_r;
  osa_out_t      out_r;
  logic          tok0_valid_r;
  logic [VW-1:0] left0_r, diag0_r, two_diag0_r;

  osa_tok_t      tok_c      [MAX_LEN+1];
  logic [VW-1:0] left_c     [MAX_LEN+1];
  logic [VW-1:0] diag_c     [MAX_LEN+1];
  logic [VW-1:0] two_diag_c [MAX_LEN+1];
  logic [VW-1:0] two_far_c  [MAX_LEN+1];
  logic [VW-1:0] prev_c     [MAX_LEN];

  osa_bc_t       bc;
  logic          in_acc, is_ref, is_query, is_finish, ref_wr;
  logic [VW-1:0] sel_v, qc_v;
  logic [6:0]    dist_v;

  assign in_stall = busy_r || ((in_data.command == CMD_FINISH) && out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_ref    = in_acc && (in_data.command == CMD_REF);
  assign is_query  = in_acc && (in_data.command == CMD_QUERY);
  assign is_finish = in_acc && (in_data.command == CMD_FINISH);
  assign ref_wr    = is_ref && (query_count_r == '0) && (32'(ref_count_r) < MAX_LEN);

  assign bc.q      = qcur_r;
  assign bc.q_prev = qprev_r;
  assign bc.i_pos  = ipos_r;
  assign bc.clr    = is_finish;

  assign qc_v = VW'(query_count_r);

  assign tok_c[0]      = '{valid: tok0_valid_r, has_left: 1'b0, ref_char: 8'h00};
  assign left_c[0]     = left0_r;
  assign diag_c[0]     = diag0_r;
  assign two_diag_c[0] = two_diag0_r;
  assign two_far_c[0]  = '0;

  always_comb begin
    sel_v = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (CW'(k + 1) == ref_count_r) begin
        sel_v = prev_c[k];
      end
    end
    if (ref_count_r == '0) begin
      sel_v = qc_v;
    end
    dist_v = (32'(sel_v) > 32'd127) ? 7'd127 : 7'(sel_v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r   <= '0;
      query_count_r <= '0;
      cnt_r         <= '0;
      ovf_r         <= 1'b0;
      busy_r        <= 1'b0;
      ipos_r        <= 1'b0;
      qcur_r        <= '0;
      qprev_r       <= '0;
      out_valid_r   <= 1'b0;
      tok0_valid_r  <= 1'b0;
    end else begin
      tok0_valid_r <= is_query && (32'(query_count_r) < MAX_LEN) && (ref_count_r != '0);
      if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
      if (is_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (is_ref && (query_count_r == '0)) begin
        if (32'(ref_count_r) >= MAX_LEN) begin
          ovf_r <= 1'b1;
        end else begin
          ref_count_r <= ref_count_r + CW'(1);
        end
      end
      if (is_query) begin
        if (32'(query_count_r) >= MAX_LEN) begin
          ovf_r <= 1'b1;
        end else begin
          query_count_r <= query_count_r + CW'(1);
          qprev_r       <= qcur_r;
          qcur_r        <= in_data.character;
          ipos_r        <= (query_count_r != '0);
          if (ref_count_r != '0) begin
            busy_r <= 1'b1;
            cnt_r  <= ref_count_r;
          end
        end
      end
      if (is_finish) begin
        ref_count_r   <= '0;
        query_count_r <= '0;
        ovf_r         <= 1'b0;
        qcur_r        <= '0;
        qprev_r       <= '0;
        ipos_r        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_finish) begin
      out_r.distance <= dist_v;
      out_r.overflow <= ovf_r;
    end
    if (is_query) begin
      left0_r     <= qc_v + VW'(1);
      diag0_r     <= qc_v;
      two_diag0_r <= (query_count_r == '0) ? '0 : (qc_v - VW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    osa_cell #(
      .IDX (g),
      .VW  (VW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .bc           (bc),
      .wr_en        (ref_wr && (ref_count_r == CW'(g))),
      .wr_char      (in_data.character),
      .tok_in       (tok_c[g]),
      .left_in      (left_c[g]),
      .diag_in      (diag_c[g]),
      .two_diag_in  (two_diag_c[g]),
      .two_far_in   (two_far_c[g]),
      .tok_out      (tok_c[g+1]),
      .left_out     (left_c[g+1]),
      .diag_out     (diag_c[g+1]),
      .two_diag_out (two_diag_c[g+1]),
      .two_far_out  (two_far_c[g+1]),
      .prev_out     (prev_c[g])
    );
  end

endmodule

`default_nettype wire
